@@ hw/rtl/dwm_pkg.sv @@
// ----------------------------------------------------------------------------
// dwm_pkg
// Shared types, constants and helpers of the DNA window minimizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dwm_pkg;

   localparam int KMER_LEN   = 12;
   localparam int WINDOW_LEN = 16;

   localparam int CODE_W     = 2 * KMER_LEN;
   localparam int OUT_CODE_W = 24;
   localparam int HASH_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SCAN_W     = $clog2(WINDOW_LEN + 1);

   // shift amounts of the integer hash
   localparam int MIX_SH_A = 21;
   localparam int MIX_SH_B = 24;
   localparam int MIX_SH_C = 14;
   localparam int MIX_SH_D = 28;
   localparam int MIX_SH_E = 31;

   localparam logic [1:0] MIX_STEP_0    = 2'd0;
   localparam logic [1:0] MIX_STEP_1    = 2'd1;
   localparam logic [1:0] MIX_STEP_2    = 2'd2;
   localparam logic [1:0] MIX_STEP_LAST = 2'd3;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_WRITE,
      ST_SCAN,
      ST_PICK,
      ST_DECIDE
   } dwm_state_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [CODE_W-1:0] code;
   } dwm_entry_type;

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   addr;
      dwm_entry_type       entry;
   } dwm_ring_wr_type;

   function automatic logic [1:0] base_value(input logic [7:0] ch);
      logic [1:0] v;
      case (ch)
         CHAR_C:  v = 2'd1;
         CHAR_G:  v = 2'd2;
         CHAR_T:  v = 2'd3;
         default: v = 2'd0;
      endcase
      return v;
   endfunction

   // a sum of shifted terms, then an xor-shift in every step but the last
   function automatic logic [HASH_W-1:0] mix_step(input logic [1:0] step,
                                                  input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      case (step)
         MIX_STEP_0: begin
            t = ~v + (v << MIX_SH_A);
            t = t ^ (t >> MIX_SH_B);
         end
         MIX_STEP_1: begin
            t = v + (v << 3) + (v << 8);
            t = t ^ (t >> MIX_SH_C);
         end
         MIX_STEP_2: begin
            t = v + (v << 2) + (v << 4);
            t = t ^ (t >> MIX_SH_D);
         end
         default: begin
            t = v + (v << MIX_SH_E);
         end
      endcase
      return t;
   endfunction

   function automatic logic [OUT_CODE_W-1:0] out_code(input logic [CODE_W-1:0] code);
      logic [31:0] t;
      t = 32'(code);
      return t[OUT_CODE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dna_window_minimizer_top.sv @@
// ----------------------------------------------------------------------------
// dna_window_minimizer_top
// Streaming (w,k) minimizer selector over a stream of DNA base characters.
// ----------------------------------------------------------------------------
// One item at a time. A base before a full k-mer is taken at once, a base that
// fills the ring before a full window is hashed and written, and a full-window
// base is also held by the slot-by-slot scan of the ring through its single read
// port, and by a full output when it has a pick. The result sits in an output register, so the
// next item is taken while it waits. Synchronous reset clears the stream state;
// the ring itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dna_window_minimizer_top import dwm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_base_char,
   input  wire logic                  req_seq_start,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [OUT_CODE_W-1:0]      rsp_kmer_code,
   output logic [31:0]                rsp_kmer_position,
   output logic [HASH_W-1:0]          rsp_kmer_hash
);

   dwm_state_type state_ff, state_in;

   logic [CODE_W-1:0]  code_ff, code_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        pick_pos_ff, pick_pos_in;
   logic [HASH_W-1:0]  pick_hash_ff, pick_hash_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [31:0]        p_ff, p_in;
   logic [31:0]        win_ff, win_in;
   logic [31:0]        win_m1_ff, win_m1_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [1:0]         step_ff, step_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [SLOT_W-1:0]  best_idx_ff, best_idx_in;
   logic [HASH_W-1:0]  best_hash_ff, best_hash_in;
   logic [CODE_W-1:0]  best_code_ff, best_code_in;
   logic [31:0]        pos_ff, pos_in;

   logic                  out_valid_ff, out_valid_in;
   logic [OUT_CODE_W-1:0] out_code_ff, out_code_in;
   logic [31:0]           out_pos_ff, out_pos_in;
   logic [HASH_W-1:0]     out_hash_ff, out_hash_in;

   dwm_ring_wr_type   ring_wr;
   logic [SLOT_W-1:0] ring_rd_addr;
   dwm_entry_type     ring_rd_data;

   logic               accept;
   logic [COUNT_W-1:0] cnt_eff;
   logic [CODE_W-1:0]  code_eff;
   logic               cnt_full;
   logic               early;
   logic               full_window;
   logic               scan_done;
   logic               out_free;
   logic               report;
   logic [SLOT_W:0]    rel_wide;

   dwm_ring u_ring (
      .clock   (clock),
      .wr      (ring_wr),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   assign accept      = (state_ff == ST_IDLE) && req_valid;
   assign cnt_eff     = req_seq_start ? '0 : count_ff;
   assign code_eff    = req_seq_start ? '0 : code_ff;
   assign cnt_full    = (cnt_eff == '1);
   assign early       = (cnt_eff < COUNT_W'(KMER_LEN - 1));
   assign full_window = (p_ff >= 32'(WINDOW_LEN - 1));
   assign scan_done   = (scan_ff == SCAN_W'(WINDOW_LEN));
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign report      = (pos_ff != pick_pos_ff) &&
                        ((win_ff == '0) || (pick_pos_ff == win_m1_ff) ||
                         (best_hash_ff < pick_hash_ff));

   // slot offset of the minimizer from the oldest k-mer; slot_ff is win mod W here
   always_comb begin
      if (best_idx_ff >= slot_ff) begin
         rel_wide = {1'b0, best_idx_ff} - {1'b0, slot_ff};
      end else begin
         rel_wide = {1'b0, best_idx_ff} + (SLOT_W+1)'(WINDOW_LEN) - {1'b0, slot_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !cnt_full && !early) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (step_ff == MIX_STEP_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = full_window ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!report || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_stall          = 1'b1;
      ring_wr.en         = 1'b0;
      ring_wr.addr       = slot_ff;
      ring_wr.entry.hash = hash_ff;
      ring_wr.entry.code = code_ff;
      ring_rd_addr       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_WRITE: begin
            ring_wr.en = 1'b1;
         end
         ST_SCAN: begin
            if (!scan_done) begin
               ring_rd_addr = scan_ff[SLOT_W-1:0];
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath
   always_comb begin
      code_in      = code_ff;
      count_in     = count_ff;
      pick_pos_in  = pick_pos_ff;
      pick_hash_in = pick_hash_ff;
      slot_in      = slot_ff;
      p_in         = p_ff;
      win_in       = win_ff;
      win_m1_in    = win_m1_ff;
      hash_in      = hash_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      best_idx_in  = best_idx_ff;
      best_hash_in = best_hash_ff;
      best_code_in = best_code_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_code_in  = out_code_ff;
      out_pos_in   = out_pos_ff;
      out_hash_in  = out_hash_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_seq_start) begin
                  code_in      = '0;
                  count_in     = '0;
                  pick_pos_in  = '1;
                  pick_hash_in = '1;
                  slot_in      = '0;
               end
               if (!cnt_full) begin
                  code_in  = CODE_W'({code_eff, base_value(req_base_char)});
                  count_in = cnt_eff + COUNT_W'(1);
                  p_in     = cnt_eff - COUNT_W'(KMER_LEN - 1);
                  hash_in  = 32'(CODE_W'({code_eff, base_value(req_base_char)}));
                  step_in  = MIX_STEP_0;
               end
            end
         end
         ST_HASH: begin
            hash_in   = mix_step(step_ff, hash_ff);
            step_in   = step_ff + 2'd1;
            win_in    = p_ff - 32'(WINDOW_LEN - 1);
            win_m1_in = p_ff - 32'(WINDOW_LEN);
         end
         ST_WRITE: begin
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
            scan_in = '0;
         end
         ST_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            // read data arrives in the cycle after its address; strict compare keeps lowest slot
            if (scan_ff != '0) begin
               if ((scan_ff == SCAN_W'(1)) || (ring_rd_data.hash < best_hash_ff)) begin
                  best_idx_in  = SLOT_W'(scan_ff - SCAN_W'(1));
                  best_hash_in = ring_rd_data.hash;
                  best_code_in = ring_rd_data.code;
               end
            end
         end
         ST_PICK: begin
            pos_in = win_ff + 32'(rel_wide[SLOT_W-1:0]);
         end
         ST_DECIDE: begin
            if (report && out_free) begin
               pick_pos_in  = pos_ff;
               pick_hash_in = best_hash_ff;
               out_valid_in = 1'b1;
               out_code_in  = out_code(best_code_ff);
               out_pos_in   = pos_ff;
               out_hash_in  = best_hash_ff;
            end
         end
         default: begin
            out_valid_in = out_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= '0;
         count_ff     <= '0;
         pick_pos_ff  <= '1;
         pick_hash_ff <= '1;
         slot_ff      <= '0;
         step_ff      <= MIX_STEP_0;
         scan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         count_ff     <= count_in;
         pick_pos_ff  <= pick_pos_in;
         pick_hash_ff <= pick_hash_in;
         slot_ff      <= slot_in;
         step_ff      <= step_in;
         scan_ff      <= scan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      win_ff       <= win_in;
      win_m1_ff    <= win_m1_in;
      hash_ff      <= hash_in;
      best_idx_ff  <= best_idx_in;
      best_hash_ff <= best_hash_in;
      best_code_ff <= best_code_in;
      pos_ff       <= pos_in;
      out_code_ff  <= out_code_in;
      out_pos_ff   <= out_pos_in;
      out_hash_ff  <= out_hash_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kmer_code     = out_code_ff;
   assign rsp_kmer_position = out_pos_ff;
   assign rsp_kmer_hash     = out_hash_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dwm_ring.sv @@
// ----------------------------------------------------------------------------
// dwm_ring
// Ring of k-mer hashes and codes: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwm_ring import dwm_pkg::*; (
   input  wire logic            clock,
   input  wire dwm_ring_wr_type wr,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output dwm_entry_type        rd_data
);

   dwm_entry_type mem [WINDOW_LEN];
   dwm_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_dna_window_minimizer_top.sv @@
// ----------------------------------------------------------------------------
// tb_dna_window_minimizer_top
// Self-checking bench for the streaming DNA window minimizer.
// ----------------------------------------------------------------------------
// A short opening table of bases is sent first. It covers character extremes,
// all base letters, lowercase and near-miss bytes, and a restart in the middle
// of a sequence. Then random sequences follow: mostly well-formed ACGT runs,
// some low-complexity repeats that force hash ties, and some byte noise with
// stray restarts. A local tracker of the minimizer state predicts each pick,
// and every pick the block emits is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dna_window_minimizer_top;
   import dwm_pkg::*;

   localparam int RANDOM_BASES = 1300;
   localparam int PAUSE_AT     = 700;
   localparam int HOLD_CYCLES  = 600;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [7:0] CHAR_A = 8'h41;

   typedef struct packed {
      logic [OUT_CODE_W-1:0] code;
      logic [31:0]           position;
      logic [HASH_W-1:0]     hash;
   } minimizer_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       start;
      logic       no_pick;   // item known to give no pick
   } base_row_type;

   typedef enum {SEQ_MIXED, SEQ_REPEAT, SEQ_NOISE} seq_kind_type;

   // opening rows: no restart at first, so the state straight after reset is used
   localparam base_row_type OPENING_ROWS [25] = '{
      '{8'h00,  1'b0, 1'b1}, '{8'hFF,  1'b0, 1'b1}, '{CHAR_C, 1'b0, 1'b1},
      '{CHAR_G, 1'b0, 1'b1}, '{CHAR_T, 1'b0, 1'b1}, '{CHAR_A, 1'b0, 1'b1},
      '{8'h63,  1'b0, 1'b1}, '{8'h67,  1'b0, 1'b1}, '{8'h74,  1'b0, 1'b1},
      '{8'h42,  1'b0, 1'b1}, '{8'h44,  1'b0, 1'b1}, '{8'hC3,  1'b0, 1'b1},
      '{CHAR_G, 1'b0, 1'b0}, '{8'h55,  1'b0, 1'b0}, '{CHAR_T, 1'b1, 1'b1},
      '{CHAR_T, 1'b0, 1'b1}, '{CHAR_T, 1'b0, 1'b1}, '{CHAR_T, 1'b0, 1'b1},
      '{CHAR_T, 1'b0, 1'b1}, '{CHAR_G, 1'b0, 1'b1}, '{CHAR_G, 1'b0, 1'b1},
      '{CHAR_G, 1'b0, 1'b1}, '{CHAR_G, 1'b0, 1'b1}, '{CHAR_C, 1'b0, 1'b1},
      '{CHAR_C, 1'b0, 1'b1}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_base_char;
   logic                  req_seq_start;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [OUT_CODE_W-1:0] rsp_kmer_code;
   logic [31:0]           rsp_kmer_position;
   logic [HASH_W-1:0]     rsp_kmer_hash;

   // tracker state
   logic [CODE_W-1:0] roll_code;
   logic [31:0]       bases_seen;
   logic [31:0]       prev_pos;
   logic [HASH_W-1:0] prev_hash;
   logic [HASH_W-1:0] slot_hash [WINDOW_LEN];
   logic [CODE_W-1:0] slot_code [WINDOW_LEN];

   minimizer_type expected_picks [$];
   int unsigned   mismatches = 0;
   int unsigned   picks_seen = 0;
   int unsigned   bases_sent = 0;
   int unsigned   cycles = 0;
   bit            hold_active = 1'b0;

   dna_window_minimizer_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_base_char     (req_base_char),
      .req_seq_start     (req_seq_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kmer_code     (rsp_kmer_code),
      .rsp_kmer_position (rsp_kmer_position),
      .rsp_kmer_hash     (rsp_kmer_hash)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [HASH_W-1:0] scramble32(input logic [31:0] key);
      logic [31:0] v;
      v = ~key + (key << MIX_SH_A);
      v = v ^ (v >> MIX_SH_B);
      v = v + (v << 3) + (v << 8);
      v = v ^ (v >> MIX_SH_C);
      v = v + (v << 2) + (v << 4);
      v = v ^ (v >> MIX_SH_D);
      v = v + (v << MIX_SH_E);
      return v;
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] ch;
      case ($urandom_range(0, 3))
         0:       ch = CHAR_A;
         1:       ch = CHAR_C;
         2:       ch = CHAR_G;
         default: ch = CHAR_T;
      endcase
      return ch;
   endfunction

   // takes one base into the tracker and says whether a new minimizer is picked
   task automatic advance_minimizer(input logic [7:0] ch, input logic start,
                                    output bit fired, output minimizer_type pick);
      logic [1:0]        bv;
      logic [31:0]       p, win, rel, pos;
      logic [SLOT_W-1:0] slot, best;
      fired = 1'b0;
      pick  = '0;
      if (start) begin
         roll_code  = '0;
         bases_seen = '0;
         prev_pos   = '1;
         prev_hash  = '1;
      end
      // an exhausted count stops the sequence until the next restart
      if (bases_seen == '1)
         return;
      case (ch)
         CHAR_C:  bv = 2'd1;
         CHAR_G:  bv = 2'd2;
         CHAR_T:  bv = 2'd3;
         default: bv = 2'd0;
      endcase
      roll_code  = CODE_W'({roll_code, bv});
      bases_seen = bases_seen + 1;
      if (bases_seen < KMER_LEN)
         return;
      p    = bases_seen - KMER_LEN;
      slot = SLOT_W'(p % WINDOW_LEN);
      slot_code[slot] = roll_code;
      slot_hash[slot] = scramble32(32'(roll_code));
      if (p < WINDOW_LEN - 1)
         return;
      win  = p - (WINDOW_LEN - 1);
      best = '0;
      for (int j = 1; j < WINDOW_LEN; j++) begin
         if (slot_hash[SLOT_W'(j)] < slot_hash[best])
            best = SLOT_W'(j);
      end
      rel = (32'(best) + WINDOW_LEN - (win % WINDOW_LEN)) % WINDOW_LEN;
      pos = win + rel;
      if (pos != prev_pos &&
          (win == 0 || prev_pos == win - 1 || slot_hash[best] < prev_hash)) begin
         prev_pos      = pos;
         prev_hash     = slot_hash[best];
         fired         = 1'b1;
         pick.code     = OUT_CODE_W'(slot_code[best]);
         pick.position = pos;
         pick.hash     = slot_hash[best];
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic send_base(input logic [7:0] ch, input logic start,
                            input bit no_pick, input bit calm);
      bit            fired;
      minimizer_type pick;
      int unsigned   gap;
      req_base_char <= ch;
      req_seq_start <= start;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      advance_minimizer(ch, start, fired, pick);
      if (fired && !no_pick)
         expected_picks = {expected_picks, pick};
      bases_sent++;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int unsigned  len, period, r;
      bit           calm;
      seq_kind_type kind;
      logic [7:0]   motif [4];
      logic [7:0]   ch;
      logic         st;
      req_valid     <= 1'b0;
      req_base_char <= '0;
      req_seq_start <= 1'b0;
      reset         <= 1'b1;
      roll_code  = '0;
      bases_seen = '0;
      prev_pos   = '1;
      prev_hash  = '1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i])
         send_base(OPENING_ROWS[i].ch, OPENING_ROWS[i].start, OPENING_ROWS[i].no_pick,
                   1'b0);

      while (bases_sent < RANDOM_BASES + 25) begin
         r    = $urandom_range(0, 9);
         calm = ($urandom_range(0, 3) == 0);
         kind = (r < 6) ? SEQ_MIXED : (r < 8) ? SEQ_REPEAT : SEQ_NOISE;
         if (kind == SEQ_NOISE)
            len = $urandom_range(1, 30);
         else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(91, 400);
         else
            len = $urandom_range(28, 90);
         period = $urandom_range(1, 4);
         for (int k = 0; k < 4; k++)
            motif[k] = pick_letter();
         for (int k = 0; k < len; k++) begin
            if (kind == SEQ_NOISE) begin
               ch = 8'($urandom_range(0, 255));
               st = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
            end else begin
               // repeats give many equal hashes in one window
               if (kind == SEQ_REPEAT && $urandom_range(0, 15) != 0)
                  ch = motif[k % period];
               else if ($urandom_range(0, 19) == 0)
                  ch = 8'($urandom_range(0, 255));
               else
                  ch = pick_letter();
               st = (k == 0);
            end
            send_base(ch, st, 1'b0, calm);
            if (bases_sent == PAUSE_AT) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (expected_picks.size() != 0) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (2 * (WINDOW_LEN + 9)) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // result side pacing, with quiet stretches now and then
   initial begin : rsp_pacing
      int unsigned wait_left, since_redraw;
      bit          calm;
      wait_left    = 0;
      since_redraw = 0;
      calm         = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            since_redraw++;
            if (since_redraw == 16) begin
               since_redraw = 0;
               calm = ($urandom_range(0, 3) == 0);
            end
            wait_left = calm ? 0 : $urandom_range(0, 13);
         end else if (wait_left != 0) begin
            wait_left--;
         end
         rsp_stall <= hold_active || (wait_left != 0);
      end
   end

   // long hold-off so the output register fills and the input backs up
   initial begin : rsp_hold
      wait (picks_seen >= 25);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin : pick_check
      minimizer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         picks_seen++;
         if (expected_picks.size() == 0) begin
            report_mismatch($sformatf("unexpected pick at position %0d",
                                      rsp_kmer_position));
         end else begin
            want = expected_picks.pop_front();
            if (rsp_kmer_code !== want.code)
               report_mismatch($sformatf("kmer_code got %h want %h",
                                         rsp_kmer_code, want.code));
            if (rsp_kmer_position !== want.position)
               report_mismatch($sformatf("kmer_position got %0d want %0d",
                                         rsp_kmer_position, want.position));
            if (rsp_kmer_hash !== want.hash)
               report_mismatch($sformatf("kmer_hash got %h want %h",
                                         rsp_kmer_hash, want.hash));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
